>>> hdl/assert_macros.svh
// assertion macros included by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold on every clock edge outside reset
`define BCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// antecedent in one cycle implies consequent in the same cycle
`define BCA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define BCA_ASSERT(lbl, prop)
`define BCA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> hdl/bca_pkg.sv
// package with item types, codes and constants of the block chain allocator
`default_nettype none
package bca_pkg;
	localparam int WORD_W     = 16;
	localparam int BLOCKS_DEF = 4096;

	localparam logic [WORD_W-1:0] END_MARK   = 16'hffff;
	localparam logic [WORD_W-1:0] EMPTY_MARK = 16'h0000;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_LINK  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WORD_W-1:0] block_index;
		logic [WORD_W-1:0] next_block;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_block;
		logic [WORD_W-1:0] free_count;
		logic [1:0]        status;
	} rsp_item_t;

	// single-port access to the link table
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} tbl_req_t;
endpackage
`default_nettype wire

>>> hdl/block_chain_allocator_core.sv
// block chain allocator: link table, first-free pointer and free count
// link, and link or read out of range, go from decode to done; read waits for table data;
// allocate reads entries in two scans (block, then next free), ending if a scan runs off
// the table; free clears chain entries until it meets a mark or empty entry or leaves
// the table; the sequencer takes one item at a time and waits while a result is held
// reset: control cleared at once, then a clearing pass writes the table (entry 0 end mark)
`default_nettype none
`include "assert_macros.svh"
module block_chain_allocator_core
	import bca_pkg::*;
#(
	parameter int BLOCKS = BLOCKS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  wire req_item_t  req,
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output rsp_item_t       rsp
);
	localparam logic [WORD_W-1:0] BLOCKS_W = WORD_W'(BLOCKS);
	localparam logic [WORD_W-1:0] LAST_W   = WORD_W'(BLOCKS - 1);

	// sequencer codes
	localparam logic [3:0] S_CLEAR     = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_DECODE    = 4'd2;
	localparam logic [3:0] S_SCAN_RD   = 4'd3;
	localparam logic [3:0] S_SCAN_CHK  = 4'd4;
	localparam logic [3:0] S_FREE_RD   = 4'd5;
	localparam logic [3:0] S_FREE_CHK  = 4'd6;
	localparam logic [3:0] S_READ_WAIT = 4'd7;
	localparam logic [3:0] S_DONE      = 4'd8;

	logic [3:0]        state_q;
	logic [WORD_W-1:0] clr_q;        // clearing pass address
	logic [1:0]        op_q;
	logic [WORD_W-1:0] idx_q;
	logic [WORD_W-1:0] nxt_q;
	logic [WORD_W-1:0] ptr_q;        // shared scan / walk pointer
	logic              phase_q;      // allocate: 0 finding block, 1 finding next free
	logic [WORD_W-1:0] first_free_q;
	logic [WORD_W-1:0] unused_q;
	logic [WORD_W-1:0] res_q;
	logic [1:0]        stat_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	tbl_req_t          tbl_req;
	logic [WORD_W-1:0] tbl_rdata;

	logic idx_ok;
	logic ptr_ok;
	logic ptr_is_mark;
	logic rd_empty;
	logic out_free;

	assign idx_ok      = idx_q < BLOCKS_W;
	assign ptr_ok      = ptr_q < BLOCKS_W;
	assign ptr_is_mark = (ptr_q == END_MARK) || (ptr_q == EMPTY_MARK);
	assign rd_empty    = tbl_rdata == EMPTY_MARK;
	assign out_free    = !rsp_valid_q || rsp_ready;

	// table storage
	bca_table #(.BLOCKS(BLOCKS)) u_table (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

	// table access for each sequencer step
	always_comb begin
		tbl_req = '0;
		unique case (state_q)
			S_CLEAR: begin
				tbl_req.wr_en = 1'b1;
				tbl_req.addr  = clr_q;
				tbl_req.wdata = (clr_q == '0) ? END_MARK : EMPTY_MARK;
			end
			S_DECODE: begin
				tbl_req.addr  = idx_q;
				tbl_req.wdata = nxt_q;
				tbl_req.wr_en = (op_q == OP_LINK) && idx_ok;
				tbl_req.rd_en = (op_q == OP_READ) && idx_ok;
			end
			S_SCAN_RD: begin
				tbl_req.addr  = ptr_q;
				tbl_req.rd_en = ptr_ok;
			end
			S_SCAN_CHK: begin
				// claim the found block, marking it end-of-chain
				tbl_req.addr  = ptr_q;
				tbl_req.wdata = END_MARK;
				tbl_req.wr_en = rd_empty && !phase_q;
			end
			S_FREE_RD: begin
				tbl_req.addr  = ptr_q;
				tbl_req.rd_en = !ptr_is_mark && ptr_ok;
			end
			S_FREE_CHK: begin
				tbl_req.addr  = ptr_q;
				tbl_req.wdata = EMPTY_MARK;
				tbl_req.wr_en = !rd_empty;
			end
			default: begin
				tbl_req = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			first_free_q <= WORD_W'(1);
			unused_q     <= LAST_W;
			rsp_valid_q  <= 1'b0;
			phase_q      <= 1'b0;
		end else begin
			// a new item from the done step takes precedence over the drain
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WORD_W'(1);
					if (clr_q == LAST_W) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.operation;
						idx_q   <= req.block_index;
						nxt_q   <= req.next_block;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_q   <= '0;
					stat_q  <= STAT_OK;
					phase_q <= 1'b0;
					unique case (op_q)
						OP_ALLOC: begin
							ptr_q   <= first_free_q;
							state_q <= S_SCAN_RD;
						end
						OP_FREE: begin
							ptr_q   <= idx_q;
							state_q <= S_FREE_RD;
						end
						OP_LINK: begin
							if (!idx_ok) begin
								stat_q <= STAT_RANGE;
							end
							state_q <= S_DONE;
						end
						OP_READ: begin
							if (!idx_ok) begin
								stat_q  <= STAT_RANGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_READ_WAIT;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN_RD: begin
					if (!ptr_ok) begin
						// ran off the end: table full, or no free block after this one
						first_free_q <= BLOCKS_W;
						if (!phase_q) begin
							stat_q <= STAT_FULL;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (rd_empty && phase_q) begin
						first_free_q <= ptr_q;
						state_q      <= S_DONE;
					end else begin
						if (rd_empty) begin
							res_q   <= ptr_q;
							phase_q <= 1'b1;
							if (unused_q != '0) begin
								unused_q <= unused_q - WORD_W'(1);
							end
						end
						ptr_q   <= ptr_q + WORD_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_FREE_RD: begin
					if (ptr_is_mark) begin
						state_q <= S_DONE;
					end else if (!ptr_ok) begin
						stat_q  <= STAT_RANGE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FREE_CHK;
					end
				end
				S_FREE_CHK: begin
					if (rd_empty) begin
						state_q <= S_DONE;
					end else begin
						if (ptr_q < first_free_q) begin
							first_free_q <= ptr_q;
						end
						if (unused_q < BLOCKS_W) begin
							unused_q <= unused_q + WORD_W'(1);
						end
						ptr_q   <= tbl_rdata;
						state_q <= S_FREE_RD;
					end
				end
				S_READ_WAIT: begin
					res_q   <= tbl_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the item to the output register once it is free
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.result_block <= res_q;
			rsp_q.free_count   <= unused_q;
			rsp_q.status       <= stat_q;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// free count never exceeds the table size
	`BCA_ASSERT(a_count_bound, unused_q <= BLOCKS_W)
	// the reserved entry zero is never the allocation start point
	`BCA_ASSERT(a_first_free_nonzero, first_free_q != '0)
	// a delivered item never carries an undefined status code
	`BCA_ASSERT_IMP(a_status_code, rsp_valid, rsp.status != 2'd3)
	// an allocation only ever claims an entry inside the table
	`BCA_ASSERT_IMP(a_claim_in_range, state_q == S_SCAN_CHK && tbl_req.wr_en, ptr_q < BLOCKS_W)
endmodule
`default_nettype wire

>>> hdl/bca_table.sv
// link table memory, one access per cycle, registered read data
`default_nettype none
module bca_table
	import bca_pkg::*;
#(
	parameter int BLOCKS = BLOCKS_DEF
) (
	input  wire              clk,
	input  wire tbl_req_t    req,
	output logic [WORD_W-1:0] rdata
);
	localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

	logic [WORD_W-1:0] mem_q [BLOCKS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr[IDX_W-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.addr[IDX_W-1:0]];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire
